@@ rtl/fbpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // default configuration of the pools
    localparam int HEADER_BYTES_DEF  = 8;
    localparam int SMALL_BLOCKS_DEF  = 8;
    localparam int MEDIUM_BLOCKS_DEF = 8;
    localparam int LARGE_BLOCKS_DEF  = 4;

    // block sizes of the three pools, as powers of two
    localparam int SMALL_SHIFT  = 4;
    localparam int MEDIUM_SHIFT = 5;
    localparam int LARGE_SHIFT  = 6;
    localparam int SMALL_BYTES  = 1 << SMALL_SHIFT;
    localparam int MEDIUM_BYTES = 1 << MEDIUM_SHIFT;
    localparam int LARGE_BYTES  = 1 << LARGE_SHIFT;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int POOL_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [POOL_W-1:0] POOL_SMALL  = 2'd0;
    localparam logic [POOL_W-1:0] POOL_MEDIUM = 2'd1;
    localparam logic [POOL_W-1:0] POOL_LARGE  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_DOUBLE    = 3'd4
    } t_status;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // stack operation requested from one pool
    typedef struct packed {
        logic pop;
        logic push;
    } t_pool_ctrl;

    // what one pool reports back to the decoder
    typedef struct packed {
        logic has_free;
        logic full;
        logic blk_alloc;
    } t_pool_stat;

endpackage

@@ rtl/fbpa_pool.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pool
// One pool: LIFO free stack, free count and per-block allocated flags.
// ----------------------------------------------------------------------------
module fbpa_pool #(
    parameter int NUM_BLOCKS = fbpa_pkg::SMALL_BLOCKS_DEF,
    parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fbpa_pkg::t_pool_ctrl i_ctrl,
    input  logic [IDX_W-1:0]     i_free_idx,
    output logic [IDX_W-1:0]     o_top_idx,
    output fbpa_pkg::t_pool_stat o_stat
);
    import fbpa_pkg::*;

    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_BLOCKS);

    logic [IDX_W-1:0]      r_stack [NUM_BLOCKS];
    logic [CNT_W-1:0]      r_count;
    logic [NUM_BLOCKS-1:0] r_alloc_map;

    logic [CNT_W-1:0] top_ptr;
    logic [IDX_W-1:0] top_raw;

    assign top_ptr = r_count - 1'b1;
    assign top_raw = r_stack[top_ptr[IDX_W-1:0]];

    // out-of-range stack entries fall back to block 0
    assign o_top_idx = ({1'b0, top_raw} >= (IDX_W + 1)'(NUM_BLOCKS)) ? '0 : top_raw;

    assign o_stat.has_free  = (r_count != '0) && (r_count <= CNT_FULL);
    assign o_stat.full      = (r_count >= CNT_FULL);
    assign o_stat.blk_alloc = r_alloc_map[i_free_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_FULL;
            r_alloc_map <= '0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                r_stack[i] <= IDX_W'(NUM_BLOCKS - 1 - i);
            end
        end else if (i_ctrl.pop) begin
            r_count                <= top_ptr;
            r_alloc_map[o_top_idx] <= 1'b1;
        end else if (i_ctrl.push) begin
            r_stack[r_count[IDX_W-1:0]] <= i_free_idx;
            r_count                     <= r_count + 1'b1;
            r_alloc_map[i_free_idx]     <= 1'b0;
        end
    end

endmodule

@@ rtl/fbpa_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_decode
// Request decode: pool selection by size or address, stack control, result.
// ----------------------------------------------------------------------------
module fbpa_decode #(
    parameter int HEADER_BYTES  = fbpa_pkg::HEADER_BYTES_DEF,
    parameter int SMALL_BLOCKS  = fbpa_pkg::SMALL_BLOCKS_DEF,
    parameter int MEDIUM_BLOCKS = fbpa_pkg::MEDIUM_BLOCKS_DEF,
    parameter int LARGE_BLOCKS  = fbpa_pkg::LARGE_BLOCKS_DEF,
    parameter int S_IDX_W = (SMALL_BLOCKS > 1) ? $clog2(SMALL_BLOCKS) : 1,
    parameter int M_IDX_W = (MEDIUM_BLOCKS > 1) ? $clog2(MEDIUM_BLOCKS) : 1,
    parameter int L_IDX_W = (LARGE_BLOCKS > 1) ? $clog2(LARGE_BLOCKS) : 1
) (
    input  logic                           i_step,
    input  logic                           i_func,
    input  logic [fbpa_pkg::SIZE_W-1:0]    i_req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]    i_free_addr,
    input  logic [fbpa_pkg::ADDR_W-1:0]    i_base_addr,
    input  fbpa_pkg::t_pool_stat           i_s_stat,
    input  fbpa_pkg::t_pool_stat           i_m_stat,
    input  fbpa_pkg::t_pool_stat           i_l_stat,
    input  logic [S_IDX_W-1:0]             i_s_top,
    input  logic [M_IDX_W-1:0]             i_m_top,
    input  logic [L_IDX_W-1:0]             i_l_top,
    output fbpa_pkg::t_pool_ctrl           o_s_ctrl,
    output fbpa_pkg::t_pool_ctrl           o_m_ctrl,
    output fbpa_pkg::t_pool_ctrl           o_l_ctrl,
    output logic [S_IDX_W-1:0]             o_s_free_idx,
    output logic [M_IDX_W-1:0]             o_m_free_idx,
    output logic [L_IDX_W-1:0]             o_l_free_idx,
    output logic [fbpa_pkg::ADDR_W-1:0]    o_addr,
    output logic [fbpa_pkg::POOL_W-1:0]    o_pool_used,
    output fbpa_pkg::t_status              o_status
);
    import fbpa_pkg::*;

    localparam logic [ADDR_W-1:0] HDR      = ADDR_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] FIT_S    = SIZE_W'(SMALL_BYTES - HEADER_BYTES);
    localparam logic [SIZE_W-1:0] FIT_M    = SIZE_W'(MEDIUM_BYTES - HEADER_BYTES);
    localparam logic [SIZE_W-1:0] FIT_L    = SIZE_W'(LARGE_BYTES - HEADER_BYTES);
    localparam logic [ADDR_W-1:0] SPAN_S   = ADDR_W'(SMALL_BLOCKS * SMALL_BYTES);
    localparam logic [ADDR_W-1:0] SPAN_M   = ADDR_W'(MEDIUM_BLOCKS * MEDIUM_BYTES);
    localparam logic [ADDR_W-1:0] SPAN_L   = ADDR_W'(LARGE_BLOCKS * LARGE_BYTES);
    localparam logic [ADDR_W-1:0] START_M  = SPAN_S;
    localparam logic [ADDR_W-1:0] START_L  = SPAN_S + SPAN_M;

    // ---------------- allocate path ----------------
    logic              fit_s, fit_m, fit_l;
    logic [ADDR_W-1:0] blk_off;

    assign fit_s = (i_req_size <= FIT_S);
    assign fit_m = (i_req_size <= FIT_M);
    assign fit_l = (i_req_size <= FIT_L);

    // ---------------- free path ----------------
    logic [ADDR_W-1:0] off, rel_m, rel_l;
    logic              in_s, in_m, in_l;
    logic              align_s, align_m, align_l;

    assign off     = i_free_addr - HDR - i_base_addr;
    assign rel_m   = off - START_M;
    assign rel_l   = off - START_L;
    assign in_s    = (off < SPAN_S);
    assign in_m    = (rel_m < SPAN_M);
    assign in_l    = (rel_l < SPAN_L);
    assign align_s = (off[SMALL_SHIFT-1:0] == '0);
    assign align_m = (rel_m[MEDIUM_SHIFT-1:0] == '0);
    assign align_l = (rel_l[LARGE_SHIFT-1:0] == '0);

    assign o_s_free_idx = off[S_IDX_W+SMALL_SHIFT-1:SMALL_SHIFT];
    assign o_m_free_idx = rel_m[M_IDX_W+MEDIUM_SHIFT-1:MEDIUM_SHIFT];
    assign o_l_free_idx = rel_l[L_IDX_W+LARGE_SHIFT-1:LARGE_SHIFT];

    always_comb begin
        o_s_ctrl    = '0;
        o_m_ctrl    = '0;
        o_l_ctrl    = '0;
        o_addr      = '0;
        o_pool_used = POOL_SMALL;
        o_status    = ST_OK;
        blk_off     = '0;

        if (i_func == FUNC_ALLOC) begin
            if (fit_s) begin
                o_pool_used  = POOL_SMALL;
                o_s_ctrl.pop = i_step && i_s_stat.has_free;
                o_status     = i_s_stat.has_free ? ST_OK : ST_EMPTY;
                blk_off      = ADDR_W'(i_s_top) << SMALL_SHIFT;
            end else if (fit_m) begin
                o_pool_used  = POOL_MEDIUM;
                o_m_ctrl.pop = i_step && i_m_stat.has_free;
                o_status     = i_m_stat.has_free ? ST_OK : ST_EMPTY;
                blk_off      = START_M + (ADDR_W'(i_m_top) << MEDIUM_SHIFT);
            end else if (fit_l) begin
                o_pool_used  = POOL_LARGE;
                o_l_ctrl.pop = i_step && i_l_stat.has_free;
                o_status     = i_l_stat.has_free ? ST_OK : ST_EMPTY;
                blk_off      = START_L + (ADDR_W'(i_l_top) << LARGE_SHIFT);
            end else begin
                o_status = ST_TOO_LARGE;
            end
            if (o_status == ST_OK) begin
                o_addr = i_base_addr + blk_off + HDR;
            end
        end else begin
            // first pool whose span holds the offset decides; misalignment is unknown
            o_status = ST_UNKNOWN;
            if (in_s) begin
                if (align_s) begin
                    o_pool_used = POOL_SMALL;
                    if (!i_s_stat.blk_alloc || i_s_stat.full) begin
                        o_status = ST_DOUBLE;
                    end else begin
                        o_status      = ST_OK;
                        o_s_ctrl.push = i_step;
                    end
                end
            end else if (in_m) begin
                if (align_m) begin
                    o_pool_used = POOL_MEDIUM;
                    if (!i_m_stat.blk_alloc || i_m_stat.full) begin
                        o_status = ST_DOUBLE;
                    end else begin
                        o_status      = ST_OK;
                        o_m_ctrl.push = i_step;
                    end
                end
            end else if (in_l) begin
                if (align_l) begin
                    o_pool_used = POOL_LARGE;
                    if (!i_l_stat.blk_alloc || i_l_stat.full) begin
                        o_status = ST_DOUBLE;
                    end else begin
                        o_status      = ST_OK;
                        o_l_ctrl.push = i_step;
                    end
                end
            end
        end
    end

endmodule

@@ rtl/fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Allocates and frees fixed-size blocks from three pools behind a base address.
// ----------------------------------------------------------------------------
// Takes one allocate or free request per clock when the input is not stalled
// and gives exactly one result per request, in order. A request is captured
// in an input register; once the output register can take a result, it is
// decoded against the pool stacks, which are popped or pushed at the edge
// that loads its result into the output register, so the next request
// always sees the updated pools. The result transfers when not stalled.
// A stalled output holds its result while one more request waits in the input
// register. The configuration port is always ready; base_addr should be
// written only while no request is in flight.
module fixed_block_pool_allocator #(
    parameter int HEADER_BYTES  = fbpa_pkg::HEADER_BYTES_DEF,
    parameter int SMALL_BLOCKS  = fbpa_pkg::SMALL_BLOCKS_DEF,
    parameter int MEDIUM_BLOCKS = fbpa_pkg::MEDIUM_BLOCKS_DEF,
    parameter int LARGE_BLOCKS  = fbpa_pkg::LARGE_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fbpa_pkg::ADDR_W-1:0]   i_cfg_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [fbpa_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]   i_free_addr,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fbpa_pkg::ADDR_W-1:0]   o_addr,
    output logic [fbpa_pkg::POOL_W-1:0]   o_pool_used,
    output logic [fbpa_pkg::STATUS_W-1:0] o_status
);
    import fbpa_pkg::*;

    localparam int S_IDX_W = (SMALL_BLOCKS > 1) ? $clog2(SMALL_BLOCKS) : 1;
    localparam int M_IDX_W = (MEDIUM_BLOCKS > 1) ? $clog2(MEDIUM_BLOCKS) : 1;
    localparam int L_IDX_W = (LARGE_BLOCKS > 1) ? $clog2(LARGE_BLOCKS) : 1;

    logic [ADDR_W-1:0]   r_base_addr;

    logic                r_in_valid;
    logic                r_func;
    logic [SIZE_W-1:0]   r_req_size;
    logic [ADDR_W-1:0]   r_free_addr;

    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_addr;
    logic [POOL_W-1:0]   r_pool_used;
    logic [STATUS_W-1:0] r_status;

    logic                out_free;
    logic                step;
    logic                in_take;

    t_pool_ctrl          s_ctrl, m_ctrl, l_ctrl;
    t_pool_stat          s_stat, m_stat, l_stat;
    logic [S_IDX_W-1:0]  s_top, s_free_idx;
    logic [M_IDX_W-1:0]  m_top, m_free_idx;
    logic [L_IDX_W-1:0]  l_top, l_free_idx;
    logic [ADDR_W-1:0]   dec_addr;
    logic [POOL_W-1:0]   dec_pool;
    t_status             dec_status;

    assign o_cfg_ready = 1'b1;

    // output register can take a new result
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base_addr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func      <= i_func;
            r_req_size  <= i_req_size;
            r_free_addr <= i_free_addr;
        end
    end

    fbpa_pool #(
        .NUM_BLOCKS (SMALL_BLOCKS),
        .IDX_W      (S_IDX_W)
    ) u_pool_small (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (s_ctrl),
        .i_free_idx (s_free_idx),
        .o_top_idx  (s_top),
        .o_stat     (s_stat)
    );

    fbpa_pool #(
        .NUM_BLOCKS (MEDIUM_BLOCKS),
        .IDX_W      (M_IDX_W)
    ) u_pool_medium (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (m_ctrl),
        .i_free_idx (m_free_idx),
        .o_top_idx  (m_top),
        .o_stat     (m_stat)
    );

    fbpa_pool #(
        .NUM_BLOCKS (LARGE_BLOCKS),
        .IDX_W      (L_IDX_W)
    ) u_pool_large (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (l_ctrl),
        .i_free_idx (l_free_idx),
        .o_top_idx  (l_top),
        .o_stat     (l_stat)
    );

    fbpa_decode #(
        .HEADER_BYTES  (HEADER_BYTES),
        .SMALL_BLOCKS  (SMALL_BLOCKS),
        .MEDIUM_BLOCKS (MEDIUM_BLOCKS),
        .LARGE_BLOCKS  (LARGE_BLOCKS),
        .S_IDX_W       (S_IDX_W),
        .M_IDX_W       (M_IDX_W),
        .L_IDX_W       (L_IDX_W)
    ) u_decode (
        .i_step        (step),
        .i_func        (r_func),
        .i_req_size    (r_req_size),
        .i_free_addr   (r_free_addr),
        .i_base_addr   (r_base_addr),
        .i_s_stat      (s_stat),
        .i_m_stat      (m_stat),
        .i_l_stat      (l_stat),
        .i_s_top       (s_top),
        .i_m_top       (m_top),
        .i_l_top       (l_top),
        .o_s_ctrl      (s_ctrl),
        .o_m_ctrl      (m_ctrl),
        .o_l_ctrl      (l_ctrl),
        .o_s_free_idx  (s_free_idx),
        .o_m_free_idx  (m_free_idx),
        .o_l_free_idx  (l_free_idx),
        .o_addr        (dec_addr),
        .o_pool_used   (dec_pool),
        .o_status      (dec_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_addr      <= dec_addr;
            r_pool_used <= dec_pool;
            r_status    <= dec_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_addr      = r_addr;
    assign o_pool_used = r_pool_used;
    assign o_status    = r_status;

endmodule
